[design/bffa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OWNER_W    = 8;
  localparam int unsigned MASK_W     = 24;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  // 1 KiB subregions
  localparam int unsigned KB_SHIFT   = 10;
  // kilobyte count of a 16-bit size, and wide enough for start + length
  localparam int unsigned NEED_W     = 7;
  // widest bitmap supported
  localparam int unsigned MAX_BITS   = 64;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h2000_1000;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE = 4'd0,
    CFG_OWNER_ID  = 4'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC_SCAN,
    S_FREE_SCAN,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    bit_step;
    logic    alloc_commit;
    logic    entry_step;
    logic    free_commit;
    logic    out_load;
    status_e status;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic table_full;
    logic bad_size;
    logic run_hit;
    logic bit_last;
    logic entry_hit;
    logic entry_last;
    logic out_stall;
  } dp_sts_t;

endpackage

[design/bffa_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_req_if
// Request channel: allocate or free command words.
// ----------------------------------------------------------------------------
interface bffa_req_if;
  logic                            valid;
  logic                            ready;
  bffa_pkg::cmd_e                  cmd;
  logic [bffa_pkg::SIZE_W-1:0]     size_bytes;
  logic [bffa_pkg::ADDR_W-1:0]     free_address;

  modport source (output valid, cmd, size_bytes, free_address, input ready);
  modport sink   (input valid, cmd, size_bytes, free_address, output ready);
endinterface

[design/bffa_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_rsp_if
// Response channel: status, granted address and protection mask.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
  logic                            valid;
  logic                            ready;
  bffa_pkg::status_e               status;
  logic [bffa_pkg::ADDR_W-1:0]     block_address;
  logic [bffa_pkg::MASK_W-1:0]     access_mask;

  modport source (output valid, status, block_address, access_mask, input ready);
  modport sink   (input valid, status, block_address, access_mask, output ready);
endinterface

[design/bffa_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bffa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bffa_pkg::CFG_IDX_W-1:0]    index;
  logic [bffa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/bitmap_first_fit_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit
// First-fit allocator of 1 KiB heap subregions tracked in a free bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command word (allocate with size_bytes, or free with
//   free_address); rsp_o returns one word per command: status, granted
//   address (zero unless a successful allocate) and the low bitmap bits as
//   the protection mask. cfg_i writes heap_base (index 0) or owner_id
//   (index 1); it is always ready. The user must see that it is written
//   only while the block idles; the block itself does not enforce this.
//   A rejected allocate (table full, bad size) goes from the check
//   straight to the response state; a granted allocate stops at the bit
//   where its run completes; with no contiguous space the scan runs to
//   the last subregion. A free stops at the matching table entry, or
//   after the last entry for an unknown address.
//   The bitmap scan checks one subregion per cycle; the table lookup reads
//   one entry per cycle from the single table read port.
// One command is in flight at a time; the next is accepted the cycle after
// the response register is loaded, while that response may still wait.
// Reset: every subregion free, table empty, heap_base 0x20001000, owner 0.
// A stalled receiver holds the response register; a finished command then
// waits in the response state until the register frees up.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_unit #(
  parameter int unsigned REGION_COUNT  = 28,
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MASK_BITS     = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bffa_req_if.sink   req_i,
  bffa_rsp_if.source rsp_o,
  bffa_cfg_if.sink   cfg_i
);
  import bffa_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;
  logic     req_ready;

  // config writes go straight into the registers, never back-pressured
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  bffa_dp #(
    .REGION_COUNT  (REGION_COUNT),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MASK_BITS     (MASK_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .req_cmd_i    (req_i.cmd),
    .req_size_i   (req_i.size_bytes),
    .req_addr_i   (req_i.free_address),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_addr_o   (rsp_o.block_address),
    .rsp_mask_o   (rsp_o.access_mask)
  );

endmodule

[design/bffa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer for allocate / free: checks, scans, commit and response load.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  bffa_pkg::dp_sts_t  sts_i,
  output bffa_pkg::ctl_cmd_t ctl_o
);
  import bffa_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    ctl_o        = '0;
    ctl_o.status = res_q;
    req_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.is_free) begin
          // entry zero is read here; step the read index on to entry one
          ctl_o.entry_step = 1'b1;
          state_d          = S_FREE_SCAN;
        end else if (sts_i.table_full) begin
          res_d   = ST_FULL;
          state_d = S_RESP;
        end else if (sts_i.bad_size) begin
          res_d   = ST_BAD_SIZE;
          state_d = S_RESP;
        end else begin
          state_d = S_ALLOC_SCAN;
        end
      end
      S_ALLOC_SCAN: begin
        if (sts_i.run_hit) begin
          ctl_o.alloc_commit = 1'b1;
          res_d              = ST_OK;
          state_d            = S_RESP;
        end else if (sts_i.bit_last) begin
          res_d   = ST_NO_SPACE;
          state_d = S_RESP;
        end else begin
          ctl_o.bit_step = 1'b1;
        end
      end
      S_FREE_SCAN: begin
        if (sts_i.entry_hit) begin
          ctl_o.free_commit = 1'b1;
          res_d             = ST_OK;
          state_d           = S_RESP;
        end else if (sts_i.entry_last) begin
          res_d   = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          ctl_o.entry_step = 1'b1;
        end
      end
      S_RESP: begin
        if (!sts_i.out_stall) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/bffa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp
// Bitmap, allocation table, run scanner, config registers, output register.
// ----------------------------------------------------------------------------
module bffa_dp #(
  parameter int unsigned REGION_COUNT  = 28,
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MASK_BITS     = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bffa_pkg::ctl_cmd_t                ctl_i,
  output bffa_pkg::dp_sts_t                 sts_o,
  input  bffa_pkg::cmd_e                    req_cmd_i,
  input  logic [bffa_pkg::SIZE_W-1:0]       req_size_i,
  input  logic [bffa_pkg::ADDR_W-1:0]       req_addr_i,
  input  logic                              cfg_valid_i,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bffa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output bffa_pkg::status_e                 rsp_status_o,
  output logic [bffa_pkg::ADDR_W-1:0]       rsp_addr_o,
  output logic [bffa_pkg::MASK_W-1:0]       rsp_mask_o
);
  import bffa_pkg::*;

  localparam int unsigned SW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned LW = $clog2(REGION_COUNT + 1);
  localparam int unsigned EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WW = OWNER_W + LW + SW;
  localparam logic [SIZE_W:0]   SIZE_LIMIT = (SIZE_W + 1)'(REGION_COUNT << KB_SHIFT);
  localparam logic [SW-1:0]     BIT_LAST   = SW'(REGION_COUNT - 1);
  localparam logic [EW-1:0]     ENT_LAST   = EW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0]     ENT_MAX    = CW'(TABLE_ENTRIES);

  // control state
  logic [ADDR_W-1:0]          heap_base_q;
  logic [OWNER_W-1:0]         owner_q;
  logic [REGION_COUNT-1:0]    bitmap_q;
  logic [TABLE_ENTRIES-1:0]   valid_q;
  logic [CW-1:0]              count_q;
  logic                       rsp_valid_q;

  // working registers
  cmd_e                       cmd_q;
  logic [SIZE_W-1:0]          size_q;
  logic [ADDR_W-1:0]          addr_q;
  logic [SW-1:0]              bit_idx_q;
  logic [NEED_W-1:0]          run_q;
  logic [EW-1:0]              ent_idx_q;
  logic [EW-1:0]              cmp_idx_q;
  logic [WW-1:0]              rdata_q;
  logic [ADDR_W-1:0]          res_addr_q;
  status_e                    rsp_status_q;
  logic [ADDR_W-1:0]          rsp_addr_q;
  logic [MASK_W-1:0]          rsp_mask_q;

  logic [WW-1:0]              ent_mem [TABLE_ENTRIES];

  logic [NEED_W-1:0]          need;
  logic [NEED_W-1:0]          run_nx;
  logic [NEED_W-1:0]          alloc_start;
  logic [SW-1:0]              rd_start;
  logic [LW-1:0]              rd_len;
  logic [ADDR_W-1:0]          diff;
  logic [EW-1:0]              free_idx;
  logic [NEED_W-1:0]          rng_lo;
  logic [NEED_W-1:0]          rng_len;
  logic [REGION_COUNT-1:0]    rng;
  logic [MAX_BITS-1:0]        bm_ext;
  logic [MASK_W-1:0]          mask_nx;

  // kilobytes needed, rounded up
  assign need    = NEED_W'(size_q >> KB_SHIFT) + NEED_W'(|size_q[KB_SHIFT-1:0]);
  assign run_nx  = bitmap_q[bit_idx_q] ? run_q + NEED_W'(1) : '0;
  assign alloc_start = NEED_W'(bit_idx_q) + NEED_W'(1) - need;

  assign rd_start = rdata_q[SW-1:0];
  assign rd_len   = rdata_q[SW +: LW];
  assign diff     = addr_q - heap_base_q;

  // lowest unused table entry
  always_comb begin
    free_idx = '0;
    for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
      if (!valid_q[e]) free_idx = EW'(e);
    end
  end

  // subregion range touched by the commit
  assign rng_lo  = (cmd_q == CMD_FREE) ? NEED_W'(rd_start) : alloc_start;
  assign rng_len = (cmd_q == CMD_FREE) ? NEED_W'(rd_len)   : need;

  always_comb begin
    for (int b = 0; b < REGION_COUNT; b++) begin
      rng[b] = (NEED_W'(b) >= rng_lo) && (NEED_W'(b) < rng_lo + rng_len);
    end
  end

  assign bm_ext = MAX_BITS'(bitmap_q);

  always_comb begin
    mask_nx = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < MASK_BITS) mask_nx[b] = bm_ext[b];
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.is_free    = (cmd_q == CMD_FREE);
    sts_o.table_full = (count_q >= ENT_MAX);
    sts_o.bad_size   = (size_q == '0) || ({1'b0, size_q} > SIZE_LIMIT);
    sts_o.run_hit    = (run_nx == need);
    sts_o.bit_last   = (bit_idx_q == BIT_LAST);
    sts_o.entry_hit  = valid_q[cmp_idx_q] && (diff[KB_SHIFT-1:0] == '0) &&
                       (diff[ADDR_W-1:KB_SHIFT] == (ADDR_W - KB_SHIFT)'(rd_start));
    sts_o.entry_last = (cmp_idx_q == ENT_LAST);
    sts_o.out_stall  = rsp_valid_q && !rsp_ready_i;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
      owner_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEAP_BASE: heap_base_q <= cfg_data_i;
        CFG_OWNER_ID:  owner_q     <= cfg_data_i[OWNER_W-1:0];
        default: ;
      endcase
    end
  end

  // bitmap, table valid bits, entry count, response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q    <= '1;
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ctl_i.alloc_commit) begin
        bitmap_q          <= bitmap_q & ~rng;
        valid_q[free_idx] <= 1'b1;
        count_q           <= count_q + CW'(1);
      end else if (ctl_i.free_commit) begin
        bitmap_q           <= bitmap_q | rng;
        valid_q[cmp_idx_q] <= 1'b0;
        count_q            <= count_q - CW'(1);
      end
      if (ctl_i.out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // working registers and table memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= req_cmd_i;
      size_q     <= req_size_i;
      addr_q     <= req_addr_i;
      bit_idx_q  <= '0;
      run_q      <= '0;
      ent_idx_q  <= '0;
      res_addr_q <= '0;
    end else begin
      if (ctl_i.bit_step) begin
        bit_idx_q <= bit_idx_q + SW'(1);
        run_q     <= run_nx;
      end
      if (ctl_i.entry_step && (ent_idx_q != ENT_LAST)) begin
        ent_idx_q <= ent_idx_q + EW'(1);
      end
      if (ctl_i.alloc_commit) begin
        res_addr_q <= heap_base_q + (ADDR_W'(alloc_start[SW-1:0]) << KB_SHIFT);
      end
    end
    if (ctl_i.alloc_commit) begin
      ent_mem[free_idx] <= {owner_q, LW'(need), alloc_start[SW-1:0]};
    end
    rdata_q   <= ent_mem[ent_idx_q];
    cmp_idx_q <= ent_idx_q;
    if (ctl_i.out_load) begin
      rsp_status_q <= ctl_i.status;
      rsp_addr_q   <= res_addr_q;
      rsp_mask_q   <= mask_nx;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_addr_o   = rsp_addr_q;
  assign rsp_mask_o   = rsp_mask_q;

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count out of step with valid bits");

  a_alloc_free_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc_commit |-> !valid_q[free_idx] && (count_q < ENT_MAX))
    else $error("allocation commits into a used entry");

  a_free_valid_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.free_commit |-> valid_q[cmp_idx_q])
    else $error("free commits on an unused entry");

  a_alloc_claims_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc_commit |=> (bitmap_q & $past(rng)) == '0)
    else $error("claimed subregions still marked free");
`endif

endmodule
